// File: rtl/core/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/core/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and queue entry type.
// ----------------------------------------------------------------------------
package sha_pkg;
	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
	localparam logic [7:0] PadByte = 8'h80;
	localparam int LenOffset = 56;

	// Classified item between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       final_mark;
	} sha_item_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// File: rtl/core/sha_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input transactions into a short queue; drops empty items.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sha_pkg::sha_item_t in_item,
	output logic              q_valid,
	input  logic              q_ready,
	output sha_pkg::sha_item_t q_item
);
	import sha_pkg::*;

	sha_item_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 3'd4);
	assign push = in_valid && in_ready && (in_item.present || in_item.final_mark);
	assign q_valid = (cnt_q != 3'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

// File: rtl/core/sha_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 back end
// Absorbs bytes, pads, runs the round loop, emits the digest words.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  sha_pkg::sha_item_t q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	import sha_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001, ST_PAD = 6'b000010, ST_ROUND = 6'b000100,
		ST_ADD = 6'b001000, ST_EMIT = 6'b010000, ST_ZERO = 6'b100000
	} st_t;

	st_t st_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] len_q;
	logic [5:0] fill_q;
	logic [6:0] rnd_q;
	logic fin_q, two_q;
	logic [2:0] oidx_q;
	// marks that padding has been applied in this message
	logic pad_done_q;

	logic [31:0] t1, t2, s0, s1, wn, wt;
	logic [31:0] e, a;
	logic [5:0] fnext;

	assign q_ready = (st_q == ST_IDLE);
	assign wt = w_q[0];
	assign e = v_q[4];
	assign a = v_q[0];
	assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
		((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[rnd_q[5:0]] + wt;
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
		((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn = s1 + w_q[9] + s0 + w_q[0];
	assign fnext = fill_q + 6'd1;

	assign out_valid = (st_q == ST_EMIT);
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
			len_q <= '0; fill_q <= '0; rnd_q <= '0; fin_q <= 1'b0; two_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						fin_q <= q_item.final_mark;
						if (q_item.present) begin
							w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= q_item.data;
							len_q <= len_q + 64'd8;
							fill_q <= fnext;
							if (fnext == 6'd0) begin
								for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
								rnd_q <= '0; two_q <= 1'b0;
								st_q <= ST_ROUND;
							end else if (q_item.final_mark) st_q <= ST_PAD;
						end else st_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					// pad byte then zero the rest of the block, with the bit length in words 14-15 if it fits
					for (int i = 0; i < 16; i++) begin
						if (i >= 14 && fill_q < 6'(LenOffset)) begin
							w_q[i] <= (i == 14) ? len_q[63:32] : len_q[31:0];
						end else begin
							for (int j = 0; j < 4; j++) begin
								if (6'(4*i+j) == fill_q) w_q[i][8*(3-j) +: 8] <= PadByte;
								else if (6'(4*i+j) > fill_q) w_q[i][8*(3-j) +: 8] <= 8'h00;
							end
						end
					end
					two_q <= (fill_q >= 6'(LenOffset));
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					rnd_q <= '0;
					st_q <= ST_ROUND;
				end
				ST_ZERO: begin
					for (int i = 0; i < 14; i++) w_q[i] <= '0;
					w_q[14] <= len_q[63:32]; w_q[15] <= len_q[31:0];
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					rnd_q <= '0; two_q <= 1'b0;
					st_q <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd63) st_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (two_q) st_q <= ST_ZERO;
					else if (fin_q) begin
						st_q <= (fill_q == 6'd0 && !pad_done_q) ? ST_PAD : ST_EMIT;
					end else st_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
							len_q <= '0; fill_q <= '0; fin_q <= 1'b0;
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_done_q <= 1'b0;
		else if (st_q == ST_PAD) pad_done_q <= 1'b1;
		else if (st_q == ST_EMIT) pad_done_q <= 1'b0;
	end
endmodule

// File: rtl/core/sha256_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher top level
// One message byte per transaction; eight digest words per message.
// ----------------------------------------------------------------------------
// Byte: held in the queue, then absorbed by the back end; a byte that completes a
// 64-byte block then runs 64 rounds and the hash update.
// Final: padding and compression of one or two blocks, then eight output
// transactions, at most one per cycle.
// Reset: asynchronous, returns hash state to initial values, empties queue.
module sha256_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // msg_byte[7:0], byte_present[8], zero pad
	input  logic        s_tlast,  // final_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero pad
	output logic        m_tlast   // last_word
);
	import sha_pkg::*;

	sha_item_t in_item, q_item;
	logic q_valid, q_ready;
	logic [31:0] dw;
	logic [2:0] wi;

	assign in_item = {s_tdata[7:0], s_tdata[8], s_tlast};

	sha_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	sha_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid(m_tvalid), .out_ready(m_tready),
		.digest_word(dw), .word_index(wi), .last_word(m_tlast)
	);

	assign m_tdata = {5'b0, wi, dw};
endmodule

// File: rtl/core/sha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties of the hasher top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);
	`ASSERT_IMPL(a_last_idx, clk, arst_n, m_tvalid, m_tlast == (m_tdata[34:32] == 3'd7))
	`ASSERT_IMPL(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[39:35] == 5'd0)
	`ASSERT_NEXT(a_idx_step, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind sha256_hasher_top sha_checker u_sha_checker (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
